[rtl/mca_pkg.sv]
// Package for the modular coefficient ALU: word types, operation and
// register codes, and the shared modular double-and-add step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mca_pkg;

	localparam int CoefW = 64;
	localparam int ModW  = 63;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_NEG  = 3'd2,
		OP_SMUL = 3'd3,
		OP_PMUL = 3'd4
	} op_t;

	typedef enum logic {
		REG_MODULUS = 1'b0,
		REG_SCALAR  = 1'b1
	} reg_idx_t;

	// Word in flight through the reduction chain.
	typedef struct packed {
		logic [2:0]       op;
		logic             last;
		logic [CoefW-1:0] a_sh;
		logic [CoefW-1:0] b_sh;
		logic [CoefW-1:0] s_sh;
		logic [ModW-1:0]  ra;
		logic [ModW-1:0]  rb;
		logic [ModW-1:0]  rs;
	} red_t;

	// Word in flight through the multiply chain.
	typedef struct packed {
		logic [2:0]      op;
		logic            last;
		logic [ModW-1:0] x;
		logic [ModW-1:0] y_sh;
		logic [ModW-1:0] acc;
		logic [ModW-1:0] simple;
	} mul_t;

	// (2*r + bit_in*x) mod q, given r < q and x < q.
	function automatic logic [ModW-1:0] mod_step(input logic [ModW-1:0] r,
			input logic [ModW-1:0] x, input logic bit_in, input logic [ModW-1:0] q);
		logic [ModW:0] d;
		logic [ModW:0] e;
		d = {r, 1'b0};
		if (d >= {1'b0, q}) d = d - {1'b0, q};
		e = bit_in ? d + {1'b0, x} : d;
		if (e >= {1'b0, q}) e = e - {1'b0, q};
		return e[ModW-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/modular_coefficient_alu.sv]
// Modular coefficient ALU: one coefficient word per clock unless the output
// stalls, fully pipelined. A word passes 64 reduction cells (one operand bit
// each, reducing a, b and the scalar mod q), one setup stage, 63 double-and-add
// cells and the output register. The whole chain advances together, so a
// stalled output holds every stage.
// Write modulus and scalar only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
module modular_coefficient_alu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,  // op[2:0], coef_a[66:3], coef_b[130:67], zero
	input  wire logic         s_tlast,  // last_coeff
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // coef_out[62:0], zero
	output logic              m_tlast,  // last_out
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import mca_pkg::*;

	localparam int RedN = CoefW;
	localparam int MulN = ModW;

	logic [ModW-1:0]  modulus_q;
	logic [CoefW-1:0] scalar_q;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= ModW'(2);
			scalar_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODULUS: modulus_q <= cfg_data[ModW-1:0];
				REG_SCALAR:  scalar_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign advance  = m_tready || !m_tvalid;
	assign s_tready = advance;

	// reduction chain
	red_t red_w [0:RedN];
	logic red_v [0:RedN];

	always_comb begin
		red_w[0]      = '0;
		red_w[0].op   = s_tdata[2:0];
		red_w[0].last = s_tlast;
		red_w[0].a_sh = s_tdata[66:3];
		red_w[0].b_sh = s_tdata[130:67];
		red_w[0].s_sh = scalar_q;
	end
	assign red_v[0] = s_tvalid;

	for (genvar i = 0; i < RedN; i++) begin : g_red
		mca_red_cell u_cell (
			.clk(clk), .arst_n(arst_n), .advance(advance), .q(modulus_q),
			.in_valid(red_v[i]), .in_word(red_w[i]),
			.out_valid(red_v[i+1]), .out_word(red_w[i+1])
		);
	end

	// setup stage: simple results and multiplier select
	red_t            rr;
	mul_t            setup_nxt;
	logic [ModW:0]   sum;
	logic            setup_v_q;
	mul_t            setup_q;

	always_comb begin
		rr  = red_w[RedN];
		sum = {1'b0, rr.ra} + {1'b0, rr.rb};
		setup_nxt      = '0;
		setup_nxt.op   = rr.op;
		setup_nxt.last = rr.last;
		setup_nxt.x    = rr.ra;
		setup_nxt.y_sh = (rr.op == OP_SMUL) ? rr.rs : rr.rb;
		case (rr.op)
			OP_ADD:  setup_nxt.simple = (sum >= {1'b0, modulus_q}) ?
					ModW'(sum - {1'b0, modulus_q}) : sum[ModW-1:0];
			OP_SUB:  setup_nxt.simple = (rr.ra >= rr.rb) ? rr.ra - rr.rb :
					rr.ra + (modulus_q - rr.rb);
			OP_NEG:  setup_nxt.simple = (rr.ra == '0) ? '0 : modulus_q - rr.ra;
			default: setup_nxt.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_v_q <= 1'b0;
		end else if (advance) begin
			setup_v_q <= red_v[RedN];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			setup_q <= setup_nxt;
		end
	end

	// multiply chain
	mul_t mul_w [0:MulN];
	logic mul_v [0:MulN];

	assign mul_w[0] = setup_q;
	assign mul_v[0] = setup_v_q;

	for (genvar j = 0; j < MulN; j++) begin : g_mul
		mca_mul_cell u_cell (
			.clk(clk), .arst_n(arst_n), .advance(advance), .q(modulus_q),
			.in_valid(mul_v[j]), .in_word(mul_w[j]),
			.out_valid(mul_v[j+1]), .out_word(mul_w[j+1])
		);
	end

	// output register
	mul_t            fin;
	logic [ModW-1:0] res;
	logic            out_v_q;
	logic [ModW-1:0] out_coef_q;
	logic            out_last_q;

	always_comb begin
		fin = mul_w[MulN];
		if (modulus_q < ModW'(2)) begin
			res = '0;
		end else if (fin.op == OP_SMUL || fin.op == OP_PMUL) begin
			res = fin.acc;
		end else begin
			res = fin.simple;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= mul_v[MulN];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_coef_q <= res;
			out_last_q <= fin.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_coef_q};
	assign m_tlast  = out_last_q;

	a_out_below_q: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && modulus_q >= ModW'(2)) |-> (out_coef_q < modulus_q))
		else $error("result not reduced");
	a_small_q_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && modulus_q < ModW'(2) && $stable(modulus_q) && $past(advance))
		|-> (out_coef_q == '0))
		else $error("nonzero result with modulus below two");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (m_tready || !m_tvalid))
		else $error("input ready out of step with output");

endmodule
`default_nettype wire

[rtl/mca_red_cell.sv]
// One reduction cell: folds the top bit of each raw operand into its
// running residue mod q. Depends on mca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mca_red_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic [mca_pkg::ModW-1:0] q,
	input  wire logic                    in_valid,
	input  wire mca_pkg::red_t           in_word,
	output logic                         out_valid,
	output mca_pkg::red_t                out_word
);
	import mca_pkg::*;

	logic valid_q;
	red_t word_q;
	red_t nxt;

	always_comb begin
		nxt      = in_word;
		nxt.a_sh = {in_word.a_sh[CoefW-2:0], 1'b0};
		nxt.b_sh = {in_word.b_sh[CoefW-2:0], 1'b0};
		nxt.s_sh = {in_word.s_sh[CoefW-2:0], 1'b0};
		nxt.ra   = mod_step(in_word.ra, {{(ModW-1){1'b0}}, 1'b1}, in_word.a_sh[CoefW-1], q);
		nxt.rb   = mod_step(in_word.rb, {{(ModW-1){1'b0}}, 1'b1}, in_word.b_sh[CoefW-1], q);
		nxt.rs   = mod_step(in_word.rs, {{(ModW-1){1'b0}}, 1'b1}, in_word.s_sh[CoefW-1], q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule
`default_nettype wire

[rtl/mca_mul_cell.sv]
// One multiply cell: a double-and-add step over the top bit of the
// multiplier. Depends on mca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mca_mul_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic [mca_pkg::ModW-1:0] q,
	input  wire logic                    in_valid,
	input  wire mca_pkg::mul_t           in_word,
	output logic                         out_valid,
	output mca_pkg::mul_t                out_word
);
	import mca_pkg::*;

	logic valid_q;
	mul_t word_q;
	mul_t nxt;

	always_comb begin
		nxt      = in_word;
		nxt.y_sh = {in_word.y_sh[ModW-2:0], 1'b0};
		nxt.acc  = mod_step(in_word.acc, in_word.x, in_word.y_sh[ModW-1], q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule
`default_nettype wire

[sim/modular_coefficient_alu_tb.sv]
// Testbench for modular_coefficient_alu: streams coefficient words with random
// gaps and back-pressure, predicts each result and compares it field by field.
// Depends on mca_pkg and the modular_coefficient_alu RTL.
`timescale 1ns / 1ps
`default_nettype none
module modular_coefficient_alu_tb;
	import mca_pkg::*;

	localparam int LATENCY   = 129;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [2:0] OP_BAD5 = 3'd5;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;
	localparam logic [62:0] MOD_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [62:0] coef;
		logic        last;
	} coef_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [63:0]  cfg_data = '0;

	logic [62:0] cur_mod;
	logic [63:0] cur_scalar;
	coef_res_t   expected_q[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          words_sent = 0;
	int          idle_cycles = 0;
	bit          rx_stall_on = 1'b1;

	modular_coefficient_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [62:0] mod_of(logic [63:0] v, logic [62:0] q);
		return 63'(v % {1'b0, q});
	endfunction

	function automatic logic [62:0] mulmod(logic [62:0] x, logic [62:0] y, logic [62:0] q);
		logic [127:0] p;
		p = {65'd0, x} * {65'd0, y};
		return 63'(p % {65'd0, q});
	endfunction

	function automatic logic [62:0] predict_coef(logic [2:0] op, logic [63:0] ca,
			logic [63:0] cb);
		logic [62:0] a;
		logic [62:0] b;
		logic [63:0] s;
		if (cur_mod < 2) return '0;
		a = mod_of(ca, cur_mod);
		b = mod_of(cb, cur_mod);
		case (op)
			OP_ADD: begin
				s = {1'b0, a} + {1'b0, b};
				return (s >= {1'b0, cur_mod}) ? 63'(s - cur_mod) : s[62:0];
			end
			OP_SUB:  return (a >= b) ? a - b : a + (cur_mod - b);
			OP_NEG:  return (a == 0) ? '0 : cur_mod - a;
			OP_SMUL: return mulmod(a, mod_of(cur_scalar, cur_mod), cur_mod);
			OP_PMUL: return mulmod(a, b, cur_mod);
			default: return '0;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(19) == 0) return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Operand biased toward values below q, with edge values mixed in.
	function automatic logic [63:0] rand_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return {1'b0, cur_mod} - 1;
			2: return '1;
			3, 4: return rand64();
			default: return (cur_mod == '0) ? rand64() : rand64() % {1'b0, cur_mod};
		endcase
	endfunction

	task automatic send_word(logic [2:0] op, logic [63:0] ca, logic [63:0] cb, logic last);
		coef_res_t r;
		int gap;
		r.coef = predict_coef(op, ca, cb);
		r.last = last;
		expected_q.insert(expected_q.size(), r);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, cb, ca, op};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		gap = rand_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODULUS) cur_mod = v[62:0];
		else cur_scalar = v;
		@(posedge clk);
	endtask

	task automatic set_ring(logic [62:0] q, logic [63:0] s);
		drain();
		write_reg(REG_MODULUS, {1'b0, q});
		write_reg(REG_SCALAR, s);
	endtask

	task automatic test_directed_ops();
		set_ring(63'd97, 64'd1000);
		send_word(OP_ADD, 64'd96, 64'd96, 1'b0);
		send_word(OP_ADD, 64'd0, 64'd0, 1'b1);
		send_word(OP_SUB, 64'd3, 64'd96, 1'b0);
		send_word(OP_SUB, 64'd96, 64'd3, 1'b1);
		send_word(OP_NEG, 64'd0, 64'd5, 1'b0);
		send_word(OP_NEG, 64'd1, 64'd0, 1'b1);
		send_word(OP_SMUL, 64'd96, '1, 1'b0);
		send_word(OP_PMUL, 64'd96, 64'd96, 1'b1);
		// operands above q are reduced first
		send_word(OP_ADD, '1, '1, 1'b0);
		send_word(OP_NEG, 64'd97, 64'd0, 1'b0);
		send_word(OP_PMUL, '1, 64'h8000_0000_0000_0000, 1'b1);
		send_word(OP_BAD5, 64'd7, 64'd8, 1'b1);
		send_word(OP_BAD6, 64'd7, 64'd8, 1'b0);
		send_word(OP_BAD7, '1, '1, 1'b1);
	endtask

	task automatic test_extreme_moduli();
		set_ring(MOD_MAX, '1);
		send_word(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
		send_word(OP_SMUL, 64'h7FFF_FFFF_FFFF_FFFE, 64'd0, 1'b1);
		send_word(OP_PMUL, '1, '1, 1'b0);
		send_word(OP_SUB, 64'd0, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
		set_ring(63'd2, 64'd3);
		send_word(OP_SMUL, 64'd1, 64'd0, 1'b0);
		send_word(OP_NEG, 64'd1, 64'd0, 1'b1);
		// modulus below two zeroes every result
		set_ring(63'd1, 64'd5);
		send_word(OP_ADD, 64'd1, 64'd1, 1'b1);
		set_ring(63'd0, '0);
		send_word(OP_PMUL, '1, '1, 1'b0);
		send_word(OP_NEG, 64'd9, 64'd0, 1'b1);
		// upper cfg_data bit is dropped for the modulus
		drain();
		write_reg(REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFF1);
		send_word(OP_PMUL, rand64(), rand64(), 1'b0);
	endtask

	task automatic run_random_polys(int n_words);
		int cnt;
		int len;
		logic [2:0] op;
		cnt = 0;
		while (cnt < n_words) begin
			len = $urandom_range(16, 1);
			for (int i = 0; i < len; i++) begin
				op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
						: 3'($urandom_range(4));
				send_word(op, rand_operand(), rand_operand(), i == len - 1);
				cnt++;
			end
		end
	endtask

	task automatic test_random();
		logic [62:0] q;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: q = MOD_MAX;
				1: q = 63'($urandom_range(1000, 2));
				2: q = 63'({$urandom(), $urandom()}) | 63'h4000_0000_0000_0000;
				3: q = 63'({$urandom(), $urandom()} >> $urandom_range(62, 1));
				default: q = 63'({$urandom(), $urandom()});
			endcase
			set_ring(q, rand64());
			run_random_polys(240);
			if (ph == 2) begin
				// hold off until the pipeline is empty, then resume
				s_tvalid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
			if (ph == 4) rx_stall_on = 1'b0;
			if (ph == 5) rx_stall_on = 1'b1;
		end
	endtask

	// Result receiver: random back-pressure while rx_stall_on is set, compares against oldest prediction.
	always @(posedge clk) begin
		coef_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: coef=%0d last=%0b",
						m_tdata[62:0], m_tlast);
			end else begin
				exp_r = expected_q.pop_front();
				if (m_tdata[62:0] !== exp_r.coef || m_tlast !== exp_r.last
						|| m_tdata[63] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected coef=%0d last=%0b, got coef=%0d last=%0b",
								exp_r.coef, exp_r.last, m_tdata[62:0], m_tlast);
				end
			end
		end
		if (arst_n) m_tready <= rx_stall_on ? (rand_gap() == 0) : 1'b1;
	end

	// Watchdog: abort when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_q.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog timeout");
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		cur_mod = 63'd2;
		cur_scalar = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_extreme_moduli();
		test_random();
		drain();
		$display("Covered: %0d words, %0d results across all ops, unused codes and moduli 0..2^63-1",
				words_sent, results_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
